### design/sglf_pkg.sv
// Package for the sample gap linear filler: widths, codes, command record and FSM types.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package sglf_pkg;

    localparam int VALUE_W         = 32;          // sample width
    localparam int GAP_W           = 6;           // pending missing count
    localparam int CNT_W           = 7;           // results of one command, up to 64
    localparam int DEN_W           = 8;           // interpolation denominator 2*span
    localparam int DIVD_W          = 34;          // magnitude of twice the difference
    localparam int ACC_W           = 35;          // interpolation accumulator
    localparam int DIV_STEPS       = DIVD_W;      // one quotient bit per cycle
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam int MAX_GAP_DEF     = 63;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_fill_status;

    typedef enum logic {
        CMD_FILL   = 1'b0,
        CMD_INTERP = 1'b1
    } t_cmd_kind;

    // CMD_FILL emits value count times with the given status.
    // CMD_INTERP emits count interpolated rows from base toward value, then value.
    typedef struct packed {
        t_cmd_kind                 kind;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] base;
        logic [CNT_W-1:0]          count;
        t_fill_status              status;
        logic                      col_end;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

### design/sglf_if.sv
// Valid/ready channel interfaces for sample input and filled result output.
// Depends on sglf_pkg for field widths.
`default_nettype none

interface sglf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sglf_pkg::VALUE_W-1:0] sample_value;
    logic                                sample_present;
    logic                                column_end;

    modport source (output valid, output sample_value, output sample_present,
                    output column_end, input ready);
    modport sink   (input valid, input sample_value, input sample_present,
                    input column_end, output ready);
endinterface

interface sglf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sglf_pkg::VALUE_W-1:0] filled_value;
    logic [1:0]                          fill_status;
    logic                                run_last;
    logic                                column_done;

    modport source (output valid, output filled_value, output fill_status,
                    output run_last, output column_done, input ready);
    modport sink   (input valid, input filled_value, input fill_status,
                    input run_last, input column_done, output ready);
endinterface

`default_nettype wire

### design/sglf_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step size.
// Depends on sglf_pkg for widths.
`default_nettype none

module sglf_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sglf_pkg::DIVD_W-1:0]   i_dividend,
    input  wire logic [sglf_pkg::DEN_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [sglf_pkg::DIVD_W-1:0]        o_quotient,
    output logic [sglf_pkg::DEN_W-1:0]         o_remainder
);

    localparam int DW = sglf_pkg::DIVD_W;
    localparam int RW = sglf_pkg::DEN_W;
    localparam int CW = sglf_pkg::DIV_CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_den, n_den;
    logic [RW:0]   rem_sh;
    logic [RW:0]   rem_diff;
    logic          fits;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DW-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        fits     = (rem_sh >= {1'b0, r_den});
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_den    = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DW-2:0], fits};
            n_rem = fits ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(sglf_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

### design/sglf_cmd_fifo.sv
// Short command queue between the classifying front end and the emitting back end.
// Depends on sglf_pkg for the command record.
`default_nettype none

module sglf_cmd_fifo #(
    parameter int DEPTH = sglf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sglf_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output sglf_pkg::t_cmd     o_cmd,
    input  wire logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sglf_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue written while full");
`endif

endmodule

`default_nettype wire

### design/sglf_front.sv
// Front end: accepts sample rows, tracks the column state and issues fill commands.
// Depends on sglf_pkg and sglf_if.
`default_nettype none

module sglf_front #(
    parameter int MAX_GAP = sglf_pkg::MAX_GAP_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    sglf_in_if.sink         i_samples,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output sglf_pkg::t_cmd  o_cmd
);

    localparam int VW = sglf_pkg::VALUE_W;
    localparam int GW = sglf_pkg::GAP_W;
    localparam int CW = sglf_pkg::CNT_W;

    logic signed [VW-1:0] r_held, n_held;
    logic                 r_seen, n_seen;
    logic [GW-1:0]        r_pending, n_pending;
    logic                 accept;
    logic [CW-1:0]        gap_ext;

    assign i_samples.ready = !i_queue_full;

    always_comb begin
        accept    = i_samples.valid && i_samples.ready;
        gap_ext   = CW'(r_pending);
        n_held    = r_held;
        n_seen    = r_seen;
        n_pending = r_pending;
        o_push    = 1'b0;

        o_cmd.kind    = sglf_pkg::CMD_FILL;
        o_cmd.value   = i_samples.sample_value;
        o_cmd.base    = r_held;
        o_cmd.count   = gap_ext + 1'b1;
        o_cmd.status  = sglf_pkg::ST_NORMAL;
        o_cmd.col_end = i_samples.column_end;

        if (accept) begin
            if (i_samples.sample_present) begin
                // Interior gap: interpolate. Leading gap: repeat the new value.
                o_push = 1'b1;
                if (r_seen && (r_pending != '0)) begin
                    o_cmd.kind  = sglf_pkg::CMD_INTERP;
                    o_cmd.count = gap_ext;
                end
                n_held    = i_samples.sample_value;
                n_seen    = 1'b1;
                n_pending = '0;
            end else if (i_samples.column_end) begin
                o_push = 1'b1;
                if (r_seen) begin
                    o_cmd.value = r_held;
                end else begin
                    o_cmd.value  = '0;
                    o_cmd.count  = CW'(1);
                    o_cmd.status = sglf_pkg::ST_EMPTY;
                end
            end else if (r_pending >= GW'(MAX_GAP)) begin
                o_push       = 1'b1;
                o_cmd.value  = r_held;
                o_cmd.status = sglf_pkg::ST_OVERFLOW;
                n_pending    = '0;
            end else begin
                n_pending = r_pending + 1'b1;
            end
            if (i_samples.column_end) begin
                n_held    = '0;
                n_seen    = 1'b0;
                n_pending = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_seen    <= 1'b0;
            r_pending <= '0;
        end else begin
            r_held    <= n_held;
            r_seen    <= n_seen;
            r_pending <= n_pending;
        end
    end

`ifndef NO_ASSERTIONS
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= GW'(MAX_GAP))
        else $error("pending missing count beyond the gap limit");
`endif

endmodule

`default_nettype wire

### design/sglf_back.sv
// Back end: runs fill commands, divides once per interior gap, then steps the interpolation.
// Depends on sglf_pkg, sglf_if and sglf_div.
`default_nettype none

module sglf_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire sglf_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    sglf_out_if.source      o_results
);

    localparam int VW = sglf_pkg::VALUE_W;
    localparam int CW = sglf_pkg::CNT_W;
    localparam int RW = sglf_pkg::DEN_W;
    localparam int DW = sglf_pkg::DIVD_W;
    localparam int AW = sglf_pkg::ACC_W;

    sglf_pkg::t_back_state r_state, n_state;
    sglf_pkg::t_cmd        r_cmd, n_cmd;
    logic [CW-1:0]         r_left, n_left;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic signed [AW-1:0]  r_dq, n_dq;
    logic [RW-1:0]         r_rr, n_rr;
    logic [RW-1:0]         r_dr, n_dr;
    logic [RW-1:0]         r_den, n_den;
    logic                  r_neg, n_neg;

    logic                  r_out_valid, n_out_valid;
    logic signed [VW-1:0]  r_out_value, n_out_value;
    sglf_pkg::t_fill_status r_out_status, n_out_status;
    logic                  r_out_last, n_out_last;
    logic                  r_out_done, n_out_done;

    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [RW-1:0]         div_rem;
    logic [DW-1:0]         div_dividend;

    logic                  out_load;
    logic                  is_final;
    logic [CW-1:0]         span;
    logic signed [VW:0]    v_hi, v_lo, diff_up, diff_dn, diff_abs;
    logic [RW:0]           r_sum;
    logic                  carry;
    logic [RW:0]           r_wrap;
    logic signed [AW-1:0]  acc_next;
    logic signed [AW-1:0]  quo_ext;

    sglf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (n_den),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Datapath helpers shared by the state machine below.
    always_comb begin
        span     = r_cmd.count + 1'b1;
        v_hi     = {r_cmd.value[VW-1], r_cmd.value};
        v_lo     = {r_cmd.base[VW-1], r_cmd.base};
        diff_up  = v_hi - v_lo;
        diff_dn  = v_lo - v_hi;
        diff_abs = (r_cmd.value < r_cmd.base) ? diff_dn : diff_up;
        div_dividend = {diff_abs[VW:0], 1'b0};
        r_sum    = {1'b0, r_rr} + {1'b0, r_dr};
        carry    = (r_sum >= {1'b0, r_den});
        r_wrap   = r_sum - {1'b0, r_den};
        acc_next = r_acc + r_dq + AW'(carry);
        quo_ext  = AW'(div_quo);
        out_load = !r_out_valid || o_results.ready;
        is_final = (r_left == CW'(1));
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_left       = r_left;
        n_acc        = r_acc;
        n_dq         = r_dq;
        n_rr         = r_rr;
        n_dr         = r_dr;
        n_den        = r_den;
        n_neg        = r_neg;
        o_cmd_pop    = 1'b0;
        div_start    = 1'b0;
        n_out_valid  = out_load ? 1'b0 : r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        case (r_state)
            sglf_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_acc     = {{(AW - VW){i_cmd.base[VW-1]}}, i_cmd.base};
                    if (i_cmd.kind == sglf_pkg::CMD_INTERP) begin
                        n_left  = i_cmd.count + 1'b1;
                        n_state = sglf_pkg::BK_PREP;
                    end else begin
                        n_left  = i_cmd.count;
                        n_state = sglf_pkg::BK_EMIT;
                    end
                end
            end
            sglf_pkg::BK_PREP: begin
                // Denominator is twice the span; the running remainder starts at the span.
                div_start = 1'b1;
                n_den     = {span[RW-2:0], 1'b0};
                n_rr      = RW'(span);
                n_neg     = (r_cmd.value < r_cmd.base);
                n_state   = sglf_pkg::BK_DIV;
            end
            sglf_pkg::BK_DIV: begin
                if (div_done) begin
                    // Floor division of a signed step from the magnitude result.
                    if (!r_neg) begin
                        n_dq = quo_ext;
                        n_dr = div_rem;
                    end else if (div_rem == '0) begin
                        n_dq = -quo_ext;
                        n_dr = '0;
                    end else begin
                        n_dq = ~quo_ext;
                        n_dr = r_den - div_rem;
                    end
                    n_state = sglf_pkg::BK_EMIT;
                end
            end
            sglf_pkg::BK_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = is_final;
                    n_out_done  = is_final && r_cmd.col_end;
                    n_left      = r_left - 1'b1;
                    if (r_cmd.kind == sglf_pkg::CMD_INTERP) begin
                        n_out_status = sglf_pkg::ST_NORMAL;
                    end else begin
                        n_out_status = r_cmd.status;
                    end
                    if ((r_cmd.kind == sglf_pkg::CMD_INTERP) && !is_final) begin
                        n_acc       = acc_next;
                        n_rr        = carry ? r_wrap[RW-1:0] : r_sum[RW-1:0];
                        n_out_value = acc_next[VW-1:0];
                    end else begin
                        n_out_value = r_cmd.value;
                    end
                    if (is_final) begin
                        n_state = sglf_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = sglf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sglf_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_left       <= n_left;
        r_acc        <= n_acc;
        r_dq         <= n_dq;
        r_rr         <= n_rr;
        r_dr         <= n_dr;
        r_den        <= n_den;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

    assign o_results.valid        = r_out_valid;
    assign o_results.filled_value = r_out_value;
    assign o_results.fill_status  = r_out_status;
    assign o_results.run_last     = r_out_last;
    assign o_results.column_done  = r_out_done;

`ifndef NO_ASSERTIONS
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sglf_pkg::BK_EMIT) |-> (r_left != '0))
        else $error("emit state entered with no result left");
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == sglf_pkg::BK_DIV))
        else $error("divider finished outside the divide state");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sglf_pkg::BK_EMIT) && (r_cmd.kind == sglf_pkg::CMD_INTERP))
            |-> ((r_rr < r_den) && (r_dr < r_den)))
        else $error("interpolation remainder out of range");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_results.valid && o_results.column_done) |-> o_results.run_last)
        else $error("column end marked on a result that does not close its run");
`endif

endmodule

`default_nettype wire

### design/sample_gap_linear_filler_unit.sv
// Top level of the sample gap linear filler: front end, command queue and back end.
// Depends on sglf_pkg, sglf_if, sglf_front, sglf_cmd_fifo and sglf_back.
//
//   Channel     Dir  Handshake      Payload
//   i_samples   in   valid/ready    sample_value[31:0] s, sample_present, column_end
//   o_results   out  valid/ready    filled_value[31:0] s, fill_status[1:0],
//                                   run_last, column_done
//
// The front end takes one row per cycle while the command queue has room. A missing
// row that closes no run only updates the count and produces nothing.
// The back end takes a command when idle and emits its results one per cycle while the output
// is not stalled; an interior gap of m rows gives m+1 results after the bit-serial divider.
// Reset is synchronous and active low; it clears the column state, queue and FSM.
// A stalled output holds its result register and, through the queue, the input side.
`default_nettype none

module sample_gap_linear_filler_unit #(
    parameter int MAX_GAP     = sglf_pkg::MAX_GAP_DEF,
    parameter int QUEUE_DEPTH = sglf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sglf_in_if.sink    i_samples,
    sglf_out_if.source o_results
);

    // Commands flow from the front end through the queue to the back end.
    sglf_pkg::t_cmd push_cmd;
    sglf_pkg::t_cmd head_cmd;
    logic           push;
    logic           queue_full;
    logic           head_valid;
    logic           pop;

    // The front end owns the column state: held value, seen flag and the missing
    // count. It turns each row into at most one command and never waits on results.
    sglf_front #(
        .MAX_GAP (MAX_GAP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_samples    (i_samples),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // The queue lets the front end keep taking rows while the back end is still
    // dividing or emitting a long run.
    sglf_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // The back end expands each command into its result transfers, one per cycle while
    // the sink takes them, behind an output register so that a stalled sink does not lose a result.
    sglf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_results   (o_results)
    );

endmodule

`default_nettype wire

### tb/sv/sample_gap_linear_filler_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_gap_linear_filler_unit: drives sample rows, predicts
// the filled results in a scoreboard class and checks every result transfer in order.
// Depends on sglf_pkg, sglf_if and the RTL of the unit.

module sample_gap_linear_filler_unit_test;

    import sglf_pkg::*;

    localparam int MAX_GAP          = MAX_GAP_DEF;
    localparam int RANDOM_ROWS      = 18;       // random rows after the directed part
    localparam int CALM_ROWS        = 10;       // final rows sent without any idling
    localparam int LONG_HOLD_CYCLES = 400;      // receiver hold-off length
    localparam int DRAIN_CYCLES     = 80;       // divider plus queue latency, with margin
    localparam int TIMEOUT_NS       = 1000000;  // watchdog limit in ns, far above the slowest run

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

    // One expected result transfer.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_fill_status              status;
        logic                      run_last;
        logic                      column_done;
    } t_fill_result;

    // Column state is tracked here exactly as the unit should keep it. Each accepted row
    // appends the results it causes; each result transfer is compared with the oldest one.
    class fill_scoreboard;
        logic signed [VALUE_W-1:0] held;
        bit                        seen;
        logic [GAP_W-1:0]          gap_count;
        t_fill_result              pending_fills[$];
        int                        fail_count;
        int                        rows_noted;
        int                        results_checked;
        int                        interp_rows;
        int                        overflow_rows;
        int                        empty_columns;

        function new();
            held = '0;
            seen = 1'b0;
            gap_count = '0;
        endfunction

        // Rounded linear point k of span between v0 and v1, halves going upward.
        // The exact quotient is floored, so negative numerators need their own path.
        function logic signed [VALUE_W-1:0] interp_row(logic signed [VALUE_W-1:0] v0,
                                                       logic signed [VALUE_W-1:0] v1,
                                                       int k, int span);
            longint diff, num, den, quot;
            diff = longint'(v1) - longint'(v0);
            num  = 2 * diff * k + span;
            den  = 2 * span;
            if (num >= 0) begin
                quot = num / den;
            end else begin
                quot = -((-num + den - 1) / den);
            end
            return VALUE_W'(longint'(v0) + quot);
        endfunction

        function void note_sample(logic signed [VALUE_W-1:0] value, logic present,
                                  logic col_end);
            t_fill_result rows[$];
            int m;
            m = int'(gap_count);
            rows_noted++;
            if (present) begin
                // Leading run takes the new value; an interior run is interpolated.
                for (int k = 1; k <= m; k++) begin
                    rows.insert(rows.size(),
                                '{seen ? interp_row(held, value, k, m + 1) : value,
                                  ST_NORMAL, 1'b0, 1'b0});
                end
                if (seen) interp_rows += m;
                rows.insert(rows.size(), '{value, ST_NORMAL, 1'b0, 1'b0});
                held = value;
                seen = 1'b1;
                gap_count = '0;
            end else if (col_end) begin
                if (seen) begin
                    // Trailing run plus the end row repeat the last present value.
                    for (int k = 0; k <= m; k++) begin
                        rows.insert(rows.size(), '{held, ST_NORMAL, 1'b0, 1'b0});
                    end
                end else begin
                    rows.insert(rows.size(), '{'0, ST_EMPTY, 1'b0, 1'b0});
                    empty_columns++;
                end
            end else if (m >= MAX_GAP) begin
                // Gap too long: flush every missing row as the held value.
                for (int k = 0; k <= m; k++) begin
                    rows.insert(rows.size(), '{held, ST_OVERFLOW, 1'b0, 1'b0});
                end
                overflow_rows += m + 1;
                gap_count = '0;
            end else begin
                gap_count = GAP_W'(m + 1);
            end
            if (rows.size() > 0) begin
                rows[rows.size() - 1].run_last    = 1'b1;
                rows[rows.size() - 1].column_done = col_end;
            end
            if (col_end) begin
                held = '0;
                seen = 1'b0;
                gap_count = '0;
            end
            foreach (rows[i]) pending_fills.insert(pending_fills.size(), rows[i]);
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] value, logic [1:0] status,
                                   logic run_last, logic column_done);
            t_fill_result exp_row;
            if (pending_fills.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("[%0t] unexpected result: value %0d status %0d last %0b done %0b",
                             $realtime, value, status, run_last, column_done);
                end
                return;
            end
            exp_row = pending_fills.pop_front();
            results_checked++;
            if (value !== exp_row.value || status !== exp_row.status ||
                run_last !== exp_row.run_last || column_done !== exp_row.column_done) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("[%0t] result %0d mismatch: expected value %0d status %0d last %0b done %0b",
                             $realtime, results_checked, exp_row.value, exp_row.status,
                             exp_row.run_last, exp_row.column_done);
                    $display("    actual value %0d status %0d last %0b done %0b",
                             value, status, run_last, column_done);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold;       // asks the receiver for one long hold-off
    bit   calm;            // no idling on either side
    int   rows_sent;

    fill_scoreboard fill_sb = new();

    sglf_in_if  samples_if ();
    sglf_out_if results_if ();

    sample_gap_linear_filler_unit DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_samples (samples_if),
        .o_results (results_if)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Both channels are observed at the rising edge. The result transfer is checked before
    // the row of the same edge is noted, so the order of the two never depends on the
    // scheduler.
    always @(posedge clk) begin
        if (rst_n) begin
            if (results_if.valid && results_if.ready) begin
                fill_sb.check_result(results_if.filled_value, results_if.fill_status,
                                     results_if.run_last, results_if.column_done);
            end
            if (samples_if.valid && samples_if.ready) begin
                fill_sb.note_sample(samples_if.sample_value, samples_if.sample_present,
                                    samples_if.column_end);
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, and none once calm is set.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                results_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                results_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                results_if.ready <= 1'b1;
            end else begin
                results_if.ready <= 1'b1;
            end
        end
    end

    // Mostly extremes and small numbers, often a full random word so every bit toggles.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3: return int'($urandom_range(0, 200)) - 100;
            4: return VMAX - int'($urandom_range(0, 3));
            5: return VMIN + int'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // Missing-run length: mostly short, now and then around the overflow limit.
    function automatic int gap_len(bit allow_long);
        int r;
        r = $urandom_range(0, 99);
        if (allow_long && r < 3) return $urandom_range(MAX_GAP - 3, MAX_GAP + 5);
        if (r < 35) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(5, 20);
    endfunction

    // Offers one row, optionally after an idle burst, and returns once it is transferred.
    // Valid stays high between back-to-back rows; only the payload changes.
    task automatic send_row(logic signed [VALUE_W-1:0] value, logic present, logic col_end);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            samples_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_if.valid          <= 1'b1;
        samples_if.sample_value   <= value;
        samples_if.sample_present <= present;
        samples_if.column_end     <= col_end;
        @(posedge clk);
        while (!samples_if.ready) @(posedge clk);
        rows_sent++;
    endtask

    // Missing rows carry random values, which the unit must ignore.
    task automatic send_missing(int count);
        repeat (count) send_row(pick_value(), 1'b0, 1'b0);
    endtask

    // A well-formed column: runs of missing rows between present rows, ending either on a
    // present row or on a trailing run. No present rows at all gives an empty column.
    task automatic send_column(bit allow_long);
        int segments;
        bit end_on_present;
        segments = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
        end_on_present = (segments != 0) && ($urandom_range(0, 1) == 1);
        for (int s = 0; s < segments; s++) begin
            send_missing(gap_len(allow_long));
            send_row(pick_value(), 1'b1, end_on_present && (s == segments - 1));
        end
        if (!end_on_present) begin
            send_missing(gap_len(allow_long));
            send_row(pick_value(), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int first_random;
        int calm_start;
        samples_if.valid          = 1'b0;
        samples_if.sample_value   = '0;
        samples_if.sample_present = 1'b0;
        samples_if.column_end     = 1'b0;
        results_if.ready          = 1'b0;
        rst_n                     = 1'b0;
        long_hold                 = 1'b0;
        calm                      = 1'b0;
        rows_sent                 = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Overflow before any present value flushes zeros; the column then ends with no
        // present row, which gives one empty-column result.
        send_missing(MAX_GAP + 1);
        send_row(pick_value(), 1'b0, 1'b1);

        // Leading fill, interpolation down to VMIN and from VMIN up to VMAX, and a
        // trailing run closed by a missing end row.
        send_missing(2);
        send_row(100, 1'b1, 1'b0);
        send_missing(1);
        send_row(VMIN, 1'b1, 1'b0);
        send_missing(2);
        send_row(VMAX, 1'b1, 1'b0);
        send_missing(1);
        send_row(pick_value(), 1'b0, 1'b1);

        // A column of one present row.
        send_row(5, 1'b1, 1'b1);

        // The receiver holds off for a long stretch while the rows below keep coming, so
        // the queue fills and the input stalls.
        long_hold = 1'b1;

        // Exact halves round upward, for rising and falling steps.
        send_row(0, 1'b1, 1'b0);
        send_missing(1);
        send_row(1, 1'b1, 1'b0);
        send_missing(1);
        send_row(0, 1'b1, 1'b0);
        send_missing(1);
        send_row(-1, 1'b1, 1'b0);
        send_row(VMAX, 1'b1, 1'b0);
        send_missing(1);
        send_row(VMIN, 1'b1, 1'b1);

        // An interior overflow flushes the held value, and the row missed after the flush
        // is interpolated from it across the full range.
        send_row(VMIN, 1'b1, 1'b0);
        send_missing(MAX_GAP + 2);
        send_row(VMAX, 1'b1, 1'b1);

        // Random columns, then a last stretch with no idling at all.
        first_random = rows_sent;
        while (rows_sent - first_random < RANDOM_ROWS) begin
            send_column(1'b0);
        end
        calm = 1'b1;
        calm_start = rows_sent;
        while (rows_sent - calm_start < CALM_ROWS) begin
            send_column(1'b0);
        end

        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (fill_sb.pending_fills.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d rows and %0d results: %0d interpolated, %0d overflow-held,",
                 fill_sb.rows_noted, fill_sb.results_checked, fill_sb.interp_rows,
                 fill_sb.overflow_rows);
        $display("%0d empty columns, one long output hold-off; %0d mismatches.",
                 fill_sb.empty_columns, fill_sb.fail_count);
        if (fill_sb.fail_count == 0 && fill_sb.pending_fills.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
